// ===== rtl/rpkp_pkg.sv =====
package rpkp_pkg;

   // Keyword table geometry
   localparam int KW_COUNT        = 11;
   localparam int FIRST_LEGACY    = 8;
   localparam int KW_TEXT_BYTES   = 32;
   localparam int POS_W           = 6;
   localparam int MAX_KEYWORD_LEN_DEFAULT = 31;

   typedef logic [KW_COUNT-1:0]        kw_mask_type;
   typedef logic [POS_W-1:0]           pos_type;
   typedef logic [3:0]                 policy_type;
   typedef logic [8*KW_TEXT_BYTES-1:0] kw_text_type;

   // Source modes
   localparam logic [1:0] MODE_HEADER = 2'd0;
   localparam logic [1:0] MODE_META   = 2'd1;

   // Policy codes with a meaning of their own
   localparam policy_type CODE_NONE  = 4'd0;
   localparam policy_type CODE_EMPTY = 4'd9;

   // Bytes of interest
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // Keyword text, right aligned: last character in the low byte
   localparam kw_text_type KW_TEXT [KW_COUNT] = '{
      kw_text_type'("no-referrer"),
      kw_text_type'("unsafe-url"),
      kw_text_type'("origin"),
      kw_text_type'("origin-when-cross-origin"),
      kw_text_type'("same-origin"),
      kw_text_type'("strict-origin"),
      kw_text_type'("strict-origin-when-cross-origin"),
      kw_text_type'("no-referrer-when-downgrade"),
      kw_text_type'("never"),
      kw_text_type'("always"),
      kw_text_type'("default")
   };

   localparam pos_type KW_LEN [KW_COUNT] = '{
      6'd11, 6'd10, 6'd6, 6'd24, 6'd11, 6'd13, 6'd31, 6'd26, 6'd5, 6'd6, 6'd7
   };

   localparam policy_type KW_CODE [KW_COUNT] = '{
      4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd1, 4'd2, 4'd10
   };

   // Phase of the current token
   typedef enum logic [1:0] {
      PHASE_LEAD,
      PHASE_IN,
      PHASE_TRAIL
   } token_phase_type;

endpackage

// ===== rtl/referrer_policy_keyword_parser.sv =====
// Path: an accepted beat is held in the input register; a beat marked last sets the result
// register, from which the result beat is taken.
// Throughput: one input beat per cycle while not stalled; each byte is matched against all
// keywords at once in a single stage between the input register and the match state.
// A waiting result stalls the input only when the held input beat is also marked last.
// Reset (synchronous, active high) selects header mode, restores every keyword candidate
// and empties both the input register and the result register.
module referrer_policy_keyword_parser #(
   parameter int MAX_KEYWORD_LEN = rpkp_pkg::MAX_KEYWORD_LEN_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [1:0]            csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_char_byte,
   input  logic                  req_has_char,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [3:0]            rsp_policy_code
);

   // Pick the first keyword that matches the token in full
   function automatic rpkp_pkg::policy_type token_code(
      input rpkp_pkg::kw_mask_type mask,
      input rpkp_pkg::pos_type     pos,
      input logic                  meta
   );
      rpkp_pkg::policy_type result;
      result = rpkp_pkg::CODE_NONE;
      for (int k = rpkp_pkg::KW_COUNT - 1; k >= 0; k--) begin
         if (mask[k] && rpkp_pkg::KW_LEN[k] == pos && (k < rpkp_pkg::FIRST_LEGACY || meta)) begin
            result = rpkp_pkg::KW_CODE[k];
         end
      end
      return result;
   endfunction

   // Configuration
   logic [1:0] source_mode_ff;

   // Input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_char_ff;
   logic       s1_has_char_ff;
   logic       s1_last_ff;

   // Token state
   rpkp_pkg::kw_mask_type     mask_ff, mask_in;
   rpkp_pkg::pos_type         pos_ff, pos_in;
   rpkp_pkg::token_phase_type phase_ff, phase_in;
   logic                      nonempty_ff, nonempty_in;
   rpkp_pkg::policy_type      best_ff, best_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   rpkp_pkg::policy_type rsp_code_ff;
   rpkp_pkg::policy_type result_code;

   logic                 req_accept;
   logic                 proc_fire;
   logic                 header_mode;
   logic                 meta_mode;
   logic [7:0]           low_char;
   logic                 is_trim;
   rpkp_pkg::kw_mask_type keep_mask;
   rpkp_pkg::policy_type old_code;
   rpkp_pkg::policy_type new_code;

   // Handshake: the held beat moves on unless it needs the busy result slot
   assign proc_fire  = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !proc_fire;
   assign req_accept = req_valid && !req_stall;

   assign header_mode = (source_mode_ff == rpkp_pkg::MODE_HEADER);
   assign meta_mode   = (source_mode_ff == rpkp_pkg::MODE_META);

   // Fold upper case
   assign low_char = (s1_char_ff inside {[rpkp_pkg::CHAR_UPPER_A:rpkp_pkg::CHAR_UPPER_Z]})
                     ? s1_char_ff + rpkp_pkg::CASE_OFFSET : s1_char_ff;

   assign is_trim = s1_char_ff inside {rpkp_pkg::CHAR_SPACE, rpkp_pkg::CHAR_TAB,
                                       rpkp_pkg::CHAR_LF, rpkp_pkg::CHAR_CR};

   // Compare the byte with every keyword at the current position
   always_comb begin
      rpkp_pkg::pos_type byte_idx;
      for (int k = 0; k < rpkp_pkg::KW_COUNT; k++) begin
         byte_idx = rpkp_pkg::KW_LEN[k] - pos_ff - 6'd1;
         keep_mask[k] = (pos_ff < rpkp_pkg::KW_LEN[k]) &&
                        (rpkp_pkg::KW_TEXT[k][{byte_idx[4:0], 3'b000} +: 8] == low_char);
      end
   end

   assign old_code = token_code(mask_ff, pos_ff, meta_mode);

   // Next token state and result
   always_comb begin
      logic do_match;
      do_match    = 1'b0;
      mask_in     = mask_ff;
      pos_in      = pos_ff;
      phase_in    = phase_ff;
      nonempty_in = nonempty_ff;
      best_in     = best_ff;
      result_code = rpkp_pkg::CODE_NONE;

      if (s1_has_char_ff) begin
         if (header_mode) begin
            if (s1_char_ff == rpkp_pkg::CHAR_COMMA) begin
               if (nonempty_ff && old_code != rpkp_pkg::CODE_NONE) begin
                  best_in = old_code;
               end
               mask_in     = '1;
               pos_in      = '0;
               phase_in    = rpkp_pkg::PHASE_LEAD;
               nonempty_in = 1'b0;
            end else if (is_trim) begin
               if (phase_ff == rpkp_pkg::PHASE_IN) begin
                  phase_in = rpkp_pkg::PHASE_TRAIL;
               end
            end else begin
               // A byte after trailing whitespace spoils the token
               if (phase_ff == rpkp_pkg::PHASE_TRAIL) begin
                  mask_in = '0;
               end
               phase_in = rpkp_pkg::PHASE_IN;
               do_match = 1'b1;
            end
         end else begin
            phase_in = rpkp_pkg::PHASE_IN;
            do_match = 1'b1;
         end
      end

      if (do_match) begin
         nonempty_in = 1'b1;
         if (pos_ff >= rpkp_pkg::pos_type'(MAX_KEYWORD_LEN)) begin
            mask_in = '0;
         end else begin
            mask_in = mask_in & keep_mask;
            pos_in  = pos_ff + 6'd1;
         end
      end

      new_code = token_code(mask_in, pos_in, meta_mode);

      // Close the string on the last beat
      if (s1_last_ff) begin
         if (header_mode) begin
            result_code = (nonempty_in && new_code != rpkp_pkg::CODE_NONE) ? new_code : best_in;
         end else begin
            result_code = nonempty_in ? new_code : rpkp_pkg::CODE_EMPTY;
         end
         mask_in     = '1;
         pos_in      = '0;
         phase_in    = rpkp_pkg::PHASE_LEAD;
         nonempty_in = 1'b0;
         best_in     = rpkp_pkg::CODE_NONE;
      end
   end

   // Input register valid: load on accept, drop once processed
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (proc_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // Result register valid: set on a closing beat, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (proc_fire && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         source_mode_ff <= rpkp_pkg::MODE_HEADER;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         mask_ff        <= '1;
         pos_ff         <= '0;
         phase_ff       <= rpkp_pkg::PHASE_LEAD;
         nonempty_ff    <= 1'b0;
         best_ff        <= rpkp_pkg::CODE_NONE;
      end else begin
         if (csr_write_enable) begin
            source_mode_ff <= csr_write_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (proc_fire) begin
            mask_ff     <= mask_in;
            pos_ff      <= pos_in;
            phase_ff    <= phase_in;
            nonempty_ff <= nonempty_in;
            best_ff     <= best_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_char_ff     <= req_char_byte;
         s1_has_char_ff <= req_has_char;
         s1_last_ff     <= req_last;
      end
      if (proc_fire && s1_last_ff) begin
         rsp_code_ff <= result_code;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_policy_code = rsp_code_ff;

   // A closing beat always yields a result beat
   assert property (@(posedge clock) disable iff (reset)
      proc_fire && s1_last_ff |=> rsp_valid)
      else $error("closing beat produced no result");

   // A closing beat leaves the parse state cleared
   assert property (@(posedge clock) disable iff (reset)
      proc_fire && s1_last_ff |=> pos_ff == '0 && best_ff == rpkp_pkg::CODE_NONE && !nonempty_ff)
      else $error("parse state not cleared after closing beat");

   // Trailing whitespace only follows a non-empty token
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == rpkp_pkg::PHASE_TRAIL |-> nonempty_ff)
      else $error("trailing phase on empty token");

   // Position saturates at the keyword length limit
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= rpkp_pkg::pos_type'(MAX_KEYWORD_LEN))
      else $error("character position beyond limit");

endmodule
